/* sv/lru_key_value_cache_defines.svh */
// ----------------------------------------------------------------------------
// lru key/value cache assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef ASSERT_OFF
`define LRUKV_ASSERT_ALWAYS(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("lru cache assertion failed");
`define LRUKV_ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lru cache assertion failed");
`define LRUKV_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lru cache assertion failed");
`else
`define LRUKV_ASSERT_ALWAYS(name, clk, rstn, expr)
`define LRUKV_ASSERT_IMPLIES(name, clk, rstn, ante, cons)
`define LRUKV_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

/* sv/lrukv_pkg.sv */
// ----------------------------------------------------------------------------
// lrukv_pkg
// shared constants and beat types of the lru key/value cache
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrukv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 16;
  localparam int VALUE_W     = 32;
  localparam int CAP_W       = 5;
  localparam int APB_W       = 32;
  localparam int ADDR_W      = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic               cmd;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
  } out_item_t;

  typedef struct packed {
    logic scan;
    logic update;
    logic inc_all;
  } beat_ctl_t;

  typedef struct packed {
    logic found;
    logic free_found;
  } scan_stat_t;

endpackage

`default_nettype wire

/* sv/lrukv_ram.sv */
// ----------------------------------------------------------------------------
// lrukv_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrukv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/lrukv_entry_unit.sv */
// ----------------------------------------------------------------------------
// lrukv_entry_unit
// shared per-entry unit: key match, lru and free slot search, rank update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrukv_entry_unit import lrukv_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  beat_ctl_t                    ctl,
  input  logic [$clog2(ENTRIES)-1:0]   idx,
  input  logic                         ent_valid,
  input  logic [KEY_W-1:0]             ent_key,
  input  logic [$clog2(ENTRIES)-1:0]   ent_rank,
  input  logic [KEY_W-1:0]             key,
  input  logic [$clog2(ENTRIES+1)-1:0] used_count,
  input  logic [$clog2(ENTRIES)-1:0]   slot,
  input  logic [$clog2(ENTRIES)-1:0]   limit,
  output scan_stat_t                   stat,
  output logic [$clog2(ENTRIES)-1:0]   hit_slot,
  output logic [$clog2(ENTRIES)-1:0]   hit_rank,
  output logic [$clog2(ENTRIES)-1:0]   lru_slot,
  output logic [$clog2(ENTRIES)-1:0]   free_slot,
  output logic                         wr_en,
  output logic [$clog2(ENTRIES)-1:0]   wr_rank
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  scan_stat_t      stat_r, stat_nxt;
  logic [IW-1:0]   hit_slot_r, hit_slot_nxt;
  logic [IW-1:0]   hit_rank_r, hit_rank_nxt;
  logic [IW-1:0]   lru_slot_r, lru_slot_nxt;
  logic [IW-1:0]   free_slot_r, free_slot_nxt;
  logic [CW-1:0]   rank_p1;

  assign rank_p1 = CW'(ent_rank) + CW'(1);

  always_comb begin
    stat_nxt      = stat_r;
    hit_slot_nxt  = hit_slot_r;
    hit_rank_nxt  = hit_rank_r;
    lru_slot_nxt  = lru_slot_r;
    free_slot_nxt = free_slot_r;
    if (clear) begin
      stat_nxt = '0;
    end else if (ctl.scan) begin
      if (ent_valid && ent_key == key && !stat_r.found) begin
        stat_nxt.found = 1'b1;
        hit_slot_nxt   = idx;
        hit_rank_nxt   = ent_rank;
      end
      // least recent entry holds rank used_count-1
      if (ent_valid && rank_p1 == used_count) begin
        lru_slot_nxt = idx;
      end
      if (!ent_valid && !stat_r.free_found) begin
        stat_nxt.free_found = 1'b1;
        free_slot_nxt       = idx;
      end
    end
  end

  always_comb begin
    wr_en   = ctl.update &&
              (idx == slot || (ent_valid && (ctl.inc_all || ent_rank < limit)));
    wr_rank = (idx == slot) ? '0 : ent_rank + IW'(1);
  end

  always_ff @(posedge clk) begin
    hit_slot_r  <= hit_slot_nxt;
    hit_rank_r  <= hit_rank_nxt;
    lru_slot_r  <= lru_slot_nxt;
    free_slot_r <= free_slot_nxt;
    if (!rst_n) begin
      stat_r <= '0;
    end else begin
      stat_r <= stat_nxt;
    end
  end

  assign stat      = stat_r;
  assign hit_slot  = hit_slot_r;
  assign hit_rank  = hit_rank_r;
  assign lru_slot  = lru_slot_r;
  assign free_slot = free_slot_r;

endmodule

`default_nettype wire

/* sv/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value store with least recently used replacement
// ----------------------------------------------------------------------------
// a request runs a scan pass over the key and rank memories, then an update pass
// over the rank memory; a get miss ends after the scan pass; start is taken only when not busy
// both passes go through one entry unit
// results are strobed for one cycle, the receiver cannot stall
// reset: all entries invalid, used count zero, capacity 16, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache import lrukv_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_strobe,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  in_item_t           item_r, item_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic [IW-1:0]      limit_r, limit_nxt;
  logic               inc_all_r, inc_all_nxt;
  logic               hit_r, hit_nxt;
  logic               evict_r, evict_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               accept;
  logic               cfg_wr;
  logic               reg_idx;
  logic               clear;
  logic               evict_cond;
  logic [XW-1:0]      cap_x, cap_eff;
  beat_ctl_t          ctl;
  scan_stat_t         stat;
  logic [IW-1:0]      hit_slot, hit_rank, lru_slot, free_slot;
  logic               rank_we;
  logic [IW-1:0]      rank_wdata;
  logic [IW-1:0]      rank_rdata;
  logic [KEY_W-1:0]   key_rdata;
  logic [VALUE_W-1:0] data_rdata;
  logic               mem_rd;
  logic               key_we, data_we, data_rd;
  logic [IW-1:0]      mem_addr;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign reg_idx = paddr[ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY);
  assign prdata  = (reg_idx == REG_CAPACITY) ? APB_W'(cap_r) : '0;
  assign pready  = 1'b1;

  // capacity clamped to 1..ENTRIES
  always_comb begin
    cap_x = XW'(cap_r);
    if (cap_x == '0) begin
      cap_eff = XW'(1);
    end else if (cap_x > XW'(ENTRIES)) begin
      cap_eff = XW'(ENTRIES);
    end else begin
      cap_eff = cap_x;
    end
    evict_cond = XW'(used_r) >= cap_eff;
  end

  assign ctl.scan    = rd_vld_r && (state_r == ST_SCAN);
  assign ctl.update  = rd_vld_r && (state_r == ST_UPDATE);
  assign ctl.inc_all = inc_all_r;

  assign mem_rd   = (state_r == ST_SCAN || state_r == ST_UPDATE) &&
                    (cnt_r != CW'(ENTRIES));
  assign mem_addr = cnt_r[IW-1:0];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    item_nxt       = item_r;
    cap_nxt        = cap_r;
    valid_nxt      = valid_r;
    used_nxt       = used_r;
    slot_nxt       = slot_r;
    limit_nxt      = limit_r;
    inc_all_nxt    = inc_all_r;
    hit_nxt        = hit_r;
    evict_nxt      = evict_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    clear          = 1'b0;
    key_we         = 1'b0;
    data_we        = 1'b0;
    data_rd        = 1'b0;

    if (cfg_wr) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_item;
          cnt_nxt   = '0;
          clear     = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == CW'(ENTRIES)) begin
          state_nxt = ST_DECIDE;
        end else begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
        end
      end
      ST_DECIDE: begin
        hit_nxt   = stat.found;
        evict_nxt = 1'b0;
        cnt_nxt   = '0;
        state_nxt = ST_UPDATE;
        if (stat.found) begin
          slot_nxt    = hit_slot;
          limit_nxt   = hit_rank;
          inc_all_nxt = 1'b0;
          if (item_r.cmd == CMD_PUT) begin
            data_we = 1'b1;
          end else begin
            data_rd = 1'b1;
          end
        end else if (item_r.cmd == CMD_GET) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '0;
          state_nxt      = ST_IDLE;
        end else begin
          evict_nxt   = evict_cond;
          slot_nxt    = evict_cond ? lru_slot : free_slot;
          inc_all_nxt = 1'b1;
          key_we      = 1'b1;
          data_we     = 1'b1;
          if (!evict_cond) begin
            valid_nxt[free_slot] = 1'b1;
            used_nxt             = used_r + CW'(1);
          end
        end
      end
      ST_UPDATE: begin
        if (cnt_r == CW'(ENTRIES)) begin
          out_strobe_nxt          = 1'b1;
          out_item_nxt.hit        = hit_r;
          out_item_nxt.read_value = (hit_r && item_r.cmd == CMD_GET) ? data_rdata : '0;
          out_item_nxt.evicted    = evict_r;
          state_nxt               = ST_IDLE;
        end else begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    item_r     <= item_nxt;
    slot_r     <= slot_nxt;
    limit_r    <= limit_nxt;
    inc_all_r  <= inc_all_nxt;
    hit_r      <= hit_nxt;
    evict_r    <= evict_nxt;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      cap_r        <= CAP_RESET;
      valid_r      <= '0;
      used_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      cap_r        <= cap_nxt;
      valid_r      <= valid_nxt;
      used_r       <= used_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  lrukv_entry_unit #(
    .ENTRIES (ENTRIES)
  ) u_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (clear),
    .ctl        (ctl),
    .idx        (rd_idx_r),
    .ent_valid  (valid_r[rd_idx_r]),
    .ent_key    (key_rdata),
    .ent_rank   (rank_rdata),
    .key        (item_r.key),
    .used_count (used_r),
    .slot       (slot_r),
    .limit      (limit_r),
    .stat       (stat),
    .hit_slot   (hit_slot),
    .hit_rank   (hit_rank),
    .lru_slot   (lru_slot),
    .free_slot  (free_slot),
    .wr_en      (rank_we),
    .wr_rank    (rank_wdata)
  );

  lrukv_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (slot_nxt),
    .wr_data (item_r.key),
    .rd_en   (mem_rd && state_r == ST_SCAN),
    .rd_addr (mem_addr),
    .rd_data (key_rdata)
  );

  lrukv_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (data_we),
    .wr_addr (slot_nxt),
    .wr_data (item_r.value),
    .rd_en   (data_rd),
    .rd_addr (hit_slot),
    .rd_data (data_rdata)
  );

  lrukv_ram #(
    .WIDTH (IW),
    .DEPTH (ENTRIES)
  ) u_rank_ram (
    .clk     (clk),
    .wr_en   (rank_we),
    .wr_addr (rd_idx_r),
    .wr_data (rank_wdata),
    .rd_en   (mem_rd),
    .rd_addr (mem_addr),
    .rd_data (rank_rdata)
  );

  `LRUKV_ASSERT_IMPLIES(a_strobe_idle, clk, rst_n, out_strobe_r, state_r == ST_IDLE)
  `LRUKV_ASSERT_ALWAYS(a_used_valid, clk, rst_n, $countones(valid_r) == int'(used_r))
  `LRUKV_ASSERT_NEXT(a_accept_scan, clk, rst_n, start && !busy, state_r == ST_SCAN)
  `LRUKV_ASSERT_IMPLIES(a_evict_miss, clk, rst_n, out_strobe_r && out_item_r.evicted, !out_item_r.hit && used_r != '0)

endmodule

`default_nettype wire
